### hw/rtl/mnd_pkg.sv
// shared types and constants for the motion note detector
package mnd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 17;
    localparam int COUNT_W          = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_RISE_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FALL_THRESHOLD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CATCH_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SUM_LIMIT       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_COUNT       = 3'd4;

    localparam logic        [15:0] RISE_RESET  = 16'd500;
    localparam logic signed [16:0] FALL_RESET  = -17'sd500;
    localparam logic signed [16:0] CATCH_RESET = -17'sd2000;
    localparam logic signed [16:0] LIMIT_RESET = 17'sd0;
    localparam logic        [7:0]  MAX_RESET   = 8'd20;

    typedef struct packed {
        logic        [15:0] rise_threshold;
        logic signed [16:0] fall_threshold;
        logic signed [16:0] catch_threshold;
        logic signed [16:0] sum_limit;
        logic        [7:0]  max_count;
    } cfg_t;

endpackage

### hw/rtl/mnd_cfg_regs.sv
// configuration register file of the motion note detector
module mnd_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mnd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mnd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mnd_pkg::cfg_t                    cfg
);
    import mnd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_threshold  <= RISE_RESET;
            cfg_reg.fall_threshold  <= FALL_RESET;
            cfg_reg.catch_threshold <= CATCH_RESET;
            cfg_reg.sum_limit       <= LIMIT_RESET;
            cfg_reg.max_count       <= MAX_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RISE_THRESHOLD:  cfg_reg.rise_threshold  <= cfg_data[15:0];
                REG_FALL_THRESHOLD:  cfg_reg.fall_threshold  <= $signed(cfg_data);
                REG_CATCH_THRESHOLD: cfg_reg.catch_threshold <= $signed(cfg_data);
                REG_SUM_LIMIT:       cfg_reg.sum_limit       <= $signed(cfg_data);
                REG_MAX_COUNT:       cfg_reg.max_count       <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/mnd_core.sv
// detector state and one-step update: difference, arm, sum, counter, note
module mnd_core #(
    parameter int SAMPLE_WIDTH = mnd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  mnd_pkg::cfg_t                  cfg,
    output logic                           note
);
    import mnd_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + 2;
    localparam int CMP_W = (SUM_W > 18) ? SUM_W : 18;

    logic signed [SAMPLE_WIDTH-1:0] prev_reg;
    logic signed [SUM_W-1:0]        sum_reg, sum_next;
    logic        [COUNT_W-1:0]      count_reg, count_next;
    logic                           armed_reg, armed_next;
    logic                           falling_reg, falling_next;
    logic                           last_note_reg;

    logic signed [CMP_W-1:0]   diff;
    logic signed [SUM_W-1:0]   sum_upd;
    logic        [COUNT_W-1:0] count_upd;
    logic                      armed_upd, falling_upd, note_int, clear;

    always_comb
    begin
        diff      = CMP_W'(sample) - CMP_W'(prev_reg);
        armed_upd = armed_reg || (diff >= CMP_W'($signed({1'b0, cfg.rise_threshold})));

        if (armed_upd)
        begin
            falling_upd = (diff <= CMP_W'(cfg.fall_threshold));
            count_upd   = count_reg + COUNT_W'(1) + COUNT_W'(falling_upd);
            sum_upd     = SUM_W'(CMP_W'(sum_reg) + diff);
        end
        else
        begin
            falling_upd = falling_reg;
            count_upd   = count_reg;
            sum_upd     = '0;
        end

        // large unarmed fall counts on its own, unless the last step flagged
        if ((diff <= CMP_W'(cfg.catch_threshold)) && !last_note_reg && !armed_upd)
            note_int = 1'b1;
        else
            note_int = (CMP_W'(sum_upd) <= CMP_W'(cfg.sum_limit)) && armed_upd && falling_upd;

        clear = note_int || (count_upd >= COUNT_W'(cfg.max_count));

        armed_next   = clear ? 1'b0 : armed_upd;
        falling_next = clear ? 1'b0 : falling_upd;
        count_next   = clear ? '0 : count_upd;
        sum_next     = clear ? '0 : sum_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            armed_reg     <= 1'b0;
            falling_reg   <= 1'b0;
            last_note_reg <= 1'b0;
        end
        else if (step)
        begin
            prev_reg      <= sample;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            armed_reg     <= armed_next;
            falling_reg   <= falling_next;
            last_note_reg <= note_int;
        end
    end

    assign note = note_int;

endmodule

### hw/rtl/motion_note_detector.sv
// an accepted word waits in the input register; its note then moves into the result register
// throughput: one word per cycle; a held result stalls the input register once it is full
// sample_ready falls only while both registers are full and note_ready is low
// the one-step state update sits between the input register and result register
// reset clears configuration to defaults, detector state to zero, pipeline empty
module motion_note_detector #(
    parameter int SAMPLE_WIDTH = mnd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mnd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mnd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]   sample,
    output logic                             note_valid,
    input  logic                             note_ready,
    output logic                             note_detected
);
    import mnd_pkg::*;

    cfg_t cfg;

    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           out_valid_reg;
    logic                           note_reg;
    logic                           advance;
    logic                           note;

    assign advance      = !out_valid_reg || note_ready;
    assign sample_ready = !in_valid_reg || advance;

    mnd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mnd_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance && in_valid_reg),
        .sample (sample_reg),
        .cfg    (cfg),
        .note   (note)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
                in_valid_reg <= sample_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            sample_reg <= sample;
        if (advance && in_valid_reg)
            note_reg <= note;
    end

    assign note_valid    = out_valid_reg;
    assign note_detected = note_reg;

endmodule

### hw/rtl/mnd_checker.sv
// port-level checks for the motion note detector, bound to the top level
module mnd_checker (
    input logic clk,
    input logic rst_n,
    input logic sample_valid,
    input logic sample_ready,
    input logic note_valid,
    input logic note_ready,
    input logic note_detected
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        note_valid && !note_ready |=> note_valid && $stable(note_detected))
        else $error("stalled result word changed");

    // input stalls only when the result register is full and held
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!note_valid || note_ready) |-> sample_ready)
        else $error("input stalled while output could drain");

    // an accepted word yields a valid result when the output side takes words
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) ##1 note_ready |=> note_valid)
        else $error("result missing after accepted word");

endmodule

bind motion_note_detector mnd_checker u_mnd_checker (.*);

### sim/testbench.sv
// self-checking testbench for the motion note detector
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mnd_pkg::*;

    localparam int TOTAL_ITEMS = 1650;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SAMPLE_MIN  = -32768;
    localparam int SAMPLE_MAX  = 32767;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    sample_valid;
    logic                    sample_ready;
    logic signed [15:0]      sample;
    logic                    note_valid;
    logic                    note_ready;
    logic                    note_detected;

    // shadow of the block's registers and detector state
    cfg_t                    cfg_shadow;
    logic signed [15:0]      prev_sample;
    logic signed [17:0]      run_sum;
    logic [COUNT_W-1:0]      step_cnt;
    bit                      armed;
    bit                      falling;
    bit                      last_note;

    bit                      expected_notes[$];
    int                      errors;
    int                      items_sent;
    int                      cycle_count;
    int                      stall_left;
    bit                      tx_steady;
    bit                      rx_steady;
    int                      cur;

    motion_note_detector u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample        (sample),
        .note_valid    (note_valid),
        .note_ready    (note_ready),
        .note_detected (note_detected)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int clamp_sample(input int value);
        if (value > SAMPLE_MAX)
            return SAMPLE_MAX;
        if (value < SAMPLE_MIN)
            return SAMPLE_MIN;
        return value;
    endfunction

    // one detector step on the shadow state, returns the note flag
    function automatic bit predict_note(input logic signed [15:0] s);
        int diff;
        bit note;
        diff = int'(s) - int'(prev_sample);
        prev_sample = s;
        armed = armed || (diff >= int'(cfg_shadow.rise_threshold));
        if (armed)
        begin
            step_cnt = step_cnt + 1'b1;
            falling = (diff <= int'(cfg_shadow.fall_threshold));
            if (falling)
                step_cnt = step_cnt + 1'b1;
            run_sum = 18'(int'(run_sum) + diff);
        end
        else
            run_sum = '0;
        if (diff <= int'(cfg_shadow.catch_threshold) && !last_note && !armed)
            note = 1'b1;
        else
            note = (int'(run_sum) <= int'(cfg_shadow.sum_limit)) && armed && falling;
        if (note || step_cnt >= {1'b0, cfg_shadow.max_count})
        begin
            run_sum = '0;
            step_cnt = '0;
            armed = 1'b0;
            falling = 1'b0;
        end
        last_note = note;
        return note;
    endfunction

    // result side: random stall after each accepted word unless rx_steady is set
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            note_ready = 1'b0;
            stall_left--;
        end
        else
            note_ready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && note_valid && note_ready)
        begin
            if (expected_notes.size() == 0)
            begin
                $error("note_detected: expected none, actual %0b", note_detected);
                errors++;
            end
            else
            begin
                bit want;
                want = expected_notes.pop_front();
                if (note_detected !== want)
                begin
                    $error("note_detected: expected %0b, actual %0b", want, note_detected);
                    errors++;
                end
            end
            stall_left = rx_steady ? 0 : $urandom_range(0, 7);
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_sample(input int value);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            sample_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample = value[15:0];
        sample_valid = 1'b1;
        do
            @(posedge clk);
        while (!sample_ready);
        expected_notes.push_back(predict_note(sample));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        sample_valid = 1'b0;
        while (expected_notes.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value[CFG_DATA_W-1:0];
        case (idx)
            REG_RISE_THRESHOLD:  cfg_shadow.rise_threshold = value[15:0];
            REG_FALL_THRESHOLD:  cfg_shadow.fall_threshold = value[16:0];
            REG_CATCH_THRESHOLD: cfg_shadow.catch_threshold = value[16:0];
            REG_SUM_LIMIT:       cfg_shadow.sum_limit = value[16:0];
            REG_MAX_COUNT:       cfg_shadow.max_count = value[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic program_config(input int rise, input int fall, input int catch_lvl,
                                  input int limit, input int max_cnt);
        write_reg(REG_RISE_THRESHOLD, rise);
        write_reg(REG_FALL_THRESHOLD, fall);
        write_reg(REG_CATCH_THRESHOLD, catch_lvl);
        write_reg(REG_SUM_LIMIT, limit);
        write_reg(REG_MAX_COUNT, max_cnt);
        cfg_write = 1'b0;
    endtask

    task automatic test_default_config();
        int seq[] = '{0, 600, 700, 100, -200, -900, -900, -3000, -5500, -5500, 32767,
                      -32768, -32768, 0, 499, 999, 1000, -1, 32767, 32767, -32768, 0};
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        foreach (seq[i])
            send_sample(seq[i]);
        drain_results();
    endtask

    task automatic test_low_extremes();
        int seq[] = '{0, 0, -1, -32768, 32767, -32768, 5, 5, -5, 100, -32768, -32768};
        program_config(0, 0, 0, -65535, 1);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        foreach (seq[i])
            send_sample(seq[i]);
        drain_results();
    endtask

    task automatic test_high_extremes();
        int seq[] = '{-32768, 32767, -32768, 32767, 32767, -32768, -32768, 0,
                      32767, 100, -32768, 0};
        program_config(65535, -65535, -65535, 65535, 255);
        tx_steady = 1'b0;
        rx_steady = 1'b1;
        foreach (seq[i])
            send_sample(seq[i]);
        drain_results();
    endtask

    // max_count of zero clears the detector after every step
    task automatic test_zero_count();
        int seq[] = '{0, 600, -100, -3000, -3000, 2000, -2000, 900, -800};
        program_config(int'(RISE_RESET), int'(FALL_RESET), int'(CATCH_RESET),
                       int'(LIMIT_RESET), 0);
        tx_steady = 1'b1;
        rx_steady = 1'b0;
        foreach (seq[i])
            send_sample(seq[i]);
        drain_results();
    endtask

    // rise past the threshold, hold, then fall back with random depth
    task automatic send_note_shape();
        int up;
        int steps;
        int total_fall;
        up = int'(cfg_shadow.rise_threshold) + $urandom_range(0, 1500);
        steps = $urandom_range(1, 2);
        repeat (steps)
        begin
            cur = clamp_sample(cur + up / steps);
            send_sample(cur);
        end
        repeat ($urandom_range(0, 4))
        begin
            cur = clamp_sample(cur + $urandom_range(0, 400) - 200);
            send_sample(cur);
        end
        total_fall = up + $urandom_range(0, 3000) - 500;
        steps = $urandom_range(1, 3);
        repeat (steps)
        begin
            cur = clamp_sample(cur - total_fall / steps);
            send_sample(cur);
        end
    endtask

    task automatic test_random();
        int phase_end;
        int pick;
        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                program_config($urandom_range(0, 1) ? 65535 : 0,
                               $urandom_range(0, 1) ? -65535 : 0,
                               $urandom_range(0, 1) ? -65535 : 0,
                               $urandom_range(0, 1) ? 65535 : -65535,
                               $urandom_range(0, 1) ? 255 : $urandom_range(0, 1));
            else
                program_config($urandom_range(0, 3000), -$urandom_range(0, 3000),
                               -$urandom_range(0, 10000), $urandom_range(0, 8000) - 4000,
                               $urandom_range(1, 40));
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            phase_end = items_sent + $urandom_range(80, 200);
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    send_note_shape();
                else if (pick < 80)
                begin
                    cur = $urandom_range(0, 65535) - 32768;
                    send_sample(cur);
                end
                else if (pick < 95)
                begin
                    cur = clamp_sample(cur + $urandom_range(0, 400) - 200);
                    send_sample(cur);
                end
                else
                    drain_results();
            end
            drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_valid = 1'b0;
        sample = '0;
        note_ready = 1'b0;
        stall_left = 0;
        errors = 0;
        items_sent = 0;
        cycle_count = 0;
        cur = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        cfg_shadow.rise_threshold = RISE_RESET;
        cfg_shadow.fall_threshold = FALL_RESET;
        cfg_shadow.catch_threshold = CATCH_RESET;
        cfg_shadow.sum_limit = LIMIT_RESET;
        cfg_shadow.max_count = MAX_RESET;
        prev_sample = '0;
        run_sum = '0;
        step_cnt = '0;
        armed = 1'b0;
        falling = 1'b0;
        last_note = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_default_config();
        test_low_extremes();
        test_high_extremes();
        test_zero_count();
        test_random();

        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
